// ----- hdl/sgb_pkg.sv -----
// ----------------------------------------------------------------------------
// sgb_pkg
// Shared constants, types and helpers for the separable Gaussian blur.
// ----------------------------------------------------------------------------
`default_nettype none

package sgb_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_RADIUS = 7;
    localparam int PIX_BITS   = 16;
    localparam int LS_ROWS    = 2 * MAX_RADIUS + 1;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
    localparam int SLOT_BITS  = $clog2(LS_ROWS);
    localparam int RAD_BITS   = 3;
    localparam int TAP_BITS   = 16;
    localparam int CNT_BITS   = $clog2(LS_ROWS);
    localparam int SIZE_BITS  = 11;
    localparam int CFG_BITS   = 64;
    localparam int IDX_BITS   = 3;
    localparam int PROD_BITS  = TAP_BITS + PIX_BITS;
    localparam int ACC_BITS   = PROD_BITS + 4;
    localparam int RAM_ABITS  = SLOT_BITS + COL_BITS;
    localparam int RAM_DEPTH  = 1 << RAM_ABITS;

    typedef enum logic [IDX_BITS-1:0] {
        REG_WIDTH     = 3'd0,
        REG_HEIGHT    = 3'd1,
        REG_RADIUS    = 3'd2,
        REG_COEF_LOW  = 3'd3,
        REG_COEF_HIGH = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic accept;
        logic write_px;
        logic start_out;
        logic rd_en;
        logic mul_en;
        logic mul_h;
        logic acc_add;
        logic i_next;
        logic v_store;
        logic j_next;
        logic post;
        logic load_out;
    } sgb_cmd_t;

    typedef struct packed {
        logic func;
        logic input_complete;
        logic ready;
        logic i_last;
        logic j_last;
        logic more;
        logic out_free;
    } sgb_status_t;

    // add one half, drop the fraction, clip to the pixel range
    function automatic logic [PIX_BITS-1:0] round_sat(input logic [ACC_BITS-1:0] acc);
        logic [ACC_BITS-1:0] t;
        logic [ACC_BITS-TAP_BITS-1:0] s;
        t = acc + ACC_BITS'(1 << (TAP_BITS - 1));
        s = t[ACC_BITS-1:TAP_BITS];
        round_sat = (|s[ACC_BITS-TAP_BITS-1:PIX_BITS]) ? {PIX_BITS{1'b1}} : s[PIX_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- hdl/sgb_ram.sv -----
// ----------------------------------------------------------------------------
// sgb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sgb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/sgb_ctrl.sv -----
// ----------------------------------------------------------------------------
// sgb_ctrl
// Sequencer: accepts items, walks the vertical and horizontal tap loops and
// hands results to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sgb_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire sgb_pkg::sgb_status_t st,
    output sgb_pkg::sgb_cmd_t         cmd
);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b000000000001,
        S_DISPATCH = 12'b000000000010,
        S_WRITE    = 12'b000000000100,
        S_CHECK    = 12'b000000001000,
        S_VINIT    = 12'b000000010000,
        S_ADDR     = 12'b000000100000,
        S_MUL      = 12'b000001000000,
        S_ACC      = 12'b000010000000,
        S_VSTORE   = 12'b000100000000,
        S_HMUL     = 12'b001000000000,
        S_HACC     = 12'b010000000000,
        S_EMIT     = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic   post_reg, post_next;

    always_comb
    begin
        state_next = state_reg;
        post_next  = 1'b0;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (st.func)
                begin
                    state_next = st.ready ? S_VINIT : S_IDLE;
                end
                else
                begin
                    state_next = st.input_complete ? S_IDLE : S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.write_px = 1'b1;
                state_next   = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = st.ready ? S_VINIT : S_IDLE;
            end
            S_VINIT:
            begin
                cmd.start_out = 1'b1;
                state_next    = S_ADDR;
            end
            S_ADDR:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_add = 1'b1;
                if (st.i_last)
                begin
                    state_next = S_VSTORE;
                end
                else
                begin
                    cmd.i_next = 1'b1;
                    state_next = S_ADDR;
                end
            end
            S_VSTORE:
            begin
                cmd.v_store = 1'b1;
                state_next  = st.j_last ? S_HMUL : S_ADDR;
            end
            S_HMUL:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_h  = 1'b1;
                state_next = S_HACC;
            end
            S_HACC:
            begin
                cmd.acc_add = 1'b1;
                if (st.j_last)
                begin
                    post_next  = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.j_next = 1'b1;
                    state_next = S_HMUL;
                end
            end
            S_EMIT:
            begin
                // first cycle here folds the accumulator into the result
                if (post_reg)
                begin
                    cmd.post = 1'b1;
                end
                else if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = st.more ? S_VINIT : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            post_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            post_reg  <= post_next;
        end
    end

    a_rd_then_mul: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |=> cmd.mul_en)
        else $error("read not followed by multiply");

    a_post_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.post |=> !cmd.post && state_reg == S_EMIT)
        else $error("post repeated");

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> state_reg == S_DISPATCH)
        else $error("accept without dispatch");

endmodule

`default_nettype wire

// ----- hdl/sgb_datapath.sv -----
// ----------------------------------------------------------------------------
// sgb_datapath
// Config registers, frame counters, line store, shared multiplier and
// accumulator, row window and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sgb_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    input  wire logic [sgb_pkg::IDX_BITS-1:0]      cfg_index,
    input  wire logic [sgb_pkg::CFG_BITS-1:0]      cfg_data,
    input  wire logic                              func,
    input  wire logic [sgb_pkg::PIX_BITS-1:0]      pixel,
    input  wire logic                              out_stall,
    output logic                                   out_valid,
    output logic      [sgb_pkg::PIX_BITS-1:0]      value,
    output logic                                   last_in_run,
    output logic                                   frame_done,
    input  wire sgb_pkg::sgb_cmd_t                 cmd,
    output sgb_pkg::sgb_status_t                   st
);

    localparam int CB = sgb_pkg::COL_BITS;
    localparam int RB = sgb_pkg::ROW_BITS;
    localparam int SB = sgb_pkg::SLOT_BITS;
    localparam int NB = sgb_pkg::CNT_BITS;
    localparam int PB = sgb_pkg::PIX_BITS;
    localparam int AB = sgb_pkg::ACC_BITS;
    localparam int ZB = sgb_pkg::SIZE_BITS;
    localparam int KB = sgb_pkg::RAD_BITS;

    // configuration
    logic [ZB-1:0] width_reg, height_reg;
    logic [KB-1:0] radius_reg;
    logic [sgb_pkg::CFG_BITS-1:0] coef_low_reg, coef_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= ZB'(sgb_pkg::MAX_WIDTH);
            height_reg    <= ZB'(sgb_pkg::MAX_HEIGHT);
            radius_reg    <= '0;
            coef_low_reg  <= sgb_pkg::CFG_BITS'(16'hFFFF);
            coef_high_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                sgb_pkg::REG_WIDTH:     width_reg     <= cfg_data[ZB-1:0];
                sgb_pkg::REG_HEIGHT:    height_reg    <= cfg_data[ZB-1:0];
                sgb_pkg::REG_RADIUS:    radius_reg    <= cfg_data[KB-1:0];
                sgb_pkg::REG_COEF_LOW:  coef_low_reg  <= cfg_data;
                sgb_pkg::REG_COEF_HIGH: coef_high_reg <= cfg_data;
                default:                ;
            endcase
        end
    end

    logic [ZB-1:0] w_eff, h_eff;
    logic [CB-1:0] w1;
    logic [RB-1:0] h1;
    logic [KB-1:0] r;

    always_comb
    begin
        w_eff = (width_reg == '0) ? ZB'(1) :
                (width_reg > ZB'(sgb_pkg::MAX_WIDTH)) ? ZB'(sgb_pkg::MAX_WIDTH) : width_reg;
        h_eff = (height_reg == '0) ? ZB'(1) :
                (height_reg > ZB'(sgb_pkg::MAX_HEIGHT)) ? ZB'(sgb_pkg::MAX_HEIGHT) : height_reg;
    end
    assign w1 = CB'(w_eff - ZB'(1));
    assign h1 = RB'(h_eff - ZB'(1));
    assign r  = radius_reg;

    // frame counters
    logic [CB-1:0] in_col_reg, out_col_reg;
    logic [RB-1:0] in_row_reg, out_row_reg;
    logic [SB-1:0] in_slot_reg, out_slot_reg;
    logic          complete_reg;
    logic          func_reg;
    logic [PB-1:0] pixel_reg;
    logic [NB-1:0] n_reg;
    logic          done_pend_reg;
    logic [PB-1:0] result_reg;

    logic in_last, out_last;
    assign in_last  = (in_row_reg >= h1) && (in_col_reg >= w1);
    assign out_last = (out_row_reg >= h1) && (out_col_reg >= w1);

    // an output is ready once its clamped window has fully arrived
    logic [RB:0]   tr_sum;
    logic [CB:0]   tc_sum;
    logic [RB-1:0] tr;
    logic [CB-1:0] tc;
    logic          ready;
    assign tr_sum = {1'b0, out_row_reg} + (RB+1)'(r);
    assign tc_sum = {1'b0, out_col_reg} + (CB+1)'(r);
    assign tr = (tr_sum > {1'b0, h1}) ? h1 : tr_sum[RB-1:0];
    assign tc = (tc_sum > {1'b0, w1}) ? w1 : tc_sum[CB-1:0];
    assign ready = complete_reg || (in_row_reg > tr) ||
                   ((in_row_reg == tr) && (in_col_reg > tc));

    // tap loops
    logic [NB-1:0] i_reg, j_reg;
    logic [NB-1:0] k_end;
    assign k_end = {r, 1'b0};

    logic signed [CB+1:0] cc_s;
    logic signed [RB+1:0] rr_s;
    logic [CB-1:0] cc;
    logic [RB-1:0] rr;
    logic signed [RB:0] d;
    logic signed [SB+1:0] slot_sum;
    logic [SB-1:0] slot;

    always_comb
    begin
        cc_s = $signed({2'b00, out_col_reg}) + $signed((CB+2)'(j_reg)) -
               $signed((CB+2)'(r));
        rr_s = $signed({2'b00, out_row_reg}) + $signed((RB+2)'(i_reg)) -
               $signed((RB+2)'(r));
        if (cc_s < 0)
            cc = '0;
        else if (cc_s > $signed({2'b00, w1}))
            cc = w1;
        else
            cc = cc_s[CB-1:0];
        if (rr_s < 0)
            rr = '0;
        else if (rr_s > $signed({2'b00, h1}))
            rr = h1;
        else
            rr = rr_s[RB-1:0];
        // clamped row lies within the radius of the output row: one wrap fix
        d = $signed({1'b0, rr}) - $signed({1'b0, out_row_reg});
        slot_sum = $signed({2'b00, out_slot_reg}) + $signed(d[SB+1:0]);
        if (slot_sum < 0)
            slot = SB'(slot_sum + (SB+2)'(sgb_pkg::LS_ROWS));
        else if (slot_sum >= (SB+2)'(sgb_pkg::LS_ROWS))
            slot = SB'(slot_sum - (SB+2)'(sgb_pkg::LS_ROWS));
        else
            slot = slot_sum[SB-1:0];
    end

    // line store
    logic [PB-1:0] rd_data;
    sgb_ram #(
        .WIDTH(PB),
        .DEPTH(sgb_pkg::RAM_DEPTH)
    ) u_line_store (
        .clk    (clk),
        .wr_en  (cmd.write_px),
        .wr_addr({in_slot_reg, in_col_reg}),
        .wr_data(pixel_reg),
        .rd_en  (cmd.rd_en),
        .rd_addr({slot, cc}),
        .rd_data(rd_data)
    );

    // tap select and multiply
    logic [NB-1:0] kk;
    logic [KB-1:0] tidx;
    logic [sgb_pkg::TAP_BITS-1:0] tap;
    logic [2*sgb_pkg::CFG_BITS-1:0] coefs;
    logic [PB-1:0] rw_reg [sgb_pkg::LS_ROWS];
    logic [PB-1:0] mul_b;
    logic [sgb_pkg::PROD_BITS-1:0] prod_reg;
    logic [AB-1:0] acc_reg;

    assign kk    = cmd.mul_h ? j_reg : i_reg;
    assign tidx  = (kk >= NB'(r)) ? KB'(kk - NB'(r)) : KB'(NB'(r) - kk);
    assign coefs = {coef_high_reg, coef_low_reg};
    assign tap   = coefs[sgb_pkg::TAP_BITS*tidx +: sgb_pkg::TAP_BITS];
    assign mul_b = cmd.mul_h ? rw_reg[j_reg] : rd_data;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            prod_reg <= tap * mul_b;
        if (cmd.start_out || cmd.v_store)
            acc_reg <= '0;
        else if (cmd.acc_add)
            acc_reg <= acc_reg + AB'(prod_reg);
        if (cmd.v_store)
            rw_reg[j_reg] <= sgb_pkg::round_sat(acc_reg);
        if (cmd.accept)
        begin
            func_reg  <= func;
            pixel_reg <= pixel;
        end
        if (cmd.post)
        begin
            result_reg    <= sgb_pkg::round_sat(acc_reg);
            done_pend_reg <= out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg <= '0;
            j_reg <= '0;
            n_reg <= '0;
        end
        else
        begin
            if (cmd.accept)
                n_reg <= '0;
            else if (cmd.post)
                n_reg <= n_reg + NB'(1);
            if (cmd.start_out || cmd.v_store)
                i_reg <= '0;
            else if (cmd.i_next)
                i_reg <= i_reg + NB'(1);
            if (cmd.start_out || (cmd.v_store && j_reg == k_end))
                j_reg <= '0;
            else if (cmd.v_store || cmd.j_next)
                j_reg <= j_reg + NB'(1);
        end
    end

    // input and output position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            complete_reg <= 1'b0;
        end
        else if (cmd.post && out_last)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            complete_reg <= 1'b0;
        end
        else
        begin
            if (cmd.write_px)
            begin
                if (in_last)
                    complete_reg <= 1'b1;
                else if (in_col_reg >= w1)
                begin
                    in_col_reg  <= '0;
                    in_row_reg  <= in_row_reg + RB'(1);
                    in_slot_reg <= (in_slot_reg == SB'(sgb_pkg::LS_ROWS - 1)) ? '0 :
                                   in_slot_reg + SB'(1);
                end
                else
                    in_col_reg <= in_col_reg + CB'(1);
            end
            if (cmd.post)
            begin
                if (out_col_reg >= w1)
                begin
                    out_col_reg  <= '0;
                    out_row_reg  <= out_row_reg + RB'(1);
                    out_slot_reg <= (out_slot_reg == SB'(sgb_pkg::LS_ROWS - 1)) ? '0 :
                                    out_slot_reg + SB'(1);
                end
                else
                    out_col_reg <= out_col_reg + CB'(1);
            end
        end
    end

    // output register
    logic [NB-1:0] cap;
    logic          more;
    logic          out_valid_reg;
    assign cap  = NB'(r) + NB'(1);
    assign more = !func_reg && (n_reg < cap) && ready && !done_pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            value       <= result_reg;
            last_in_run <= !more;
            frame_done  <= done_pend_reg;
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        st.func           = func_reg;
        st.input_complete = complete_reg;
        st.ready          = ready;
        st.i_last         = (i_reg == k_end);
        st.j_last         = (j_reg == k_end);
        st.more           = more;
        st.out_free       = !out_valid_reg || !out_stall;
    end

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || !out_stall))
        else $error("output register overwritten");

    a_write_open: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_px |-> !complete_reg)
        else $error("pixel written after frame input completed");

    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.post |-> (n_reg < cap))
        else $error("too many results for one item");

endmodule

`default_nettype wire

// ----- hdl/separable_gaussian_blur.sv -----
// ----------------------------------------------------------------------------
// separable_gaussian_blur
// Streaming separable Gaussian blur over one grayscale frame.
// ----------------------------------------------------------------------------
// Items are taken one at a time. A pixel item is written into a line store
// of the last 15 rows; then every output whose clamped window is complete
// (at most radius+1) is computed and sent, the last one flagged with
// last_in_run. A drain item sends at most one pending output. Each output
// is computed on one shared 16x16 multiplier with a single line-store read
// port: for each of the 2R+1 window columns (R = radius), 2R+1 vertical taps
// are read, multiplied and summed into the row window; then the 2R+1
// horizontal taps of that window are multiplied and summed. A finished result
// waits while the output side stalls. The config port is always ready; write
// it only while the block is idle.
`default_nettype none

module separable_gaussian_blur (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [sgb_pkg::IDX_BITS-1:0]  cfg_index,
    input  wire logic [sgb_pkg::CFG_BITS-1:0]  cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          func,
    input  wire logic [sgb_pkg::PIX_BITS-1:0]  pixel,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [sgb_pkg::PIX_BITS-1:0]  value,
    output logic                               last_in_run,
    output logic                               frame_done
);

    sgb_pkg::sgb_cmd_t    cmd;
    sgb_pkg::sgb_status_t st;

    assign cfg_ready = 1'b1;

    sgb_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .st      (st),
        .cmd     (cmd)
    );

    sgb_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .func       (func),
        .pixel      (pixel),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .value      (value),
        .last_in_run(last_in_run),
        .frame_done (frame_done),
        .cmd        (cmd),
        .st         (st)
    );

endmodule

`default_nettype wire
